FILE: hw/rtl/kli_pkg.sv
package kli_pkg;

   localparam int NUM_TRACKS       = 3;
   localparam int NUM_COMP         = 3;
   localparam int KEY_W            = 16;
   localparam int SLOT_W           = 4;
   localparam int TRACK_W          = 2;
   localparam int COUNT_W          = 5;
   localparam int CSR_INDEX_W      = 2;
   localparam int MAX_KEYS_DEFAULT = 16;
   localparam int QUO_W            = 16;
   localparam int DIV_CNT_W        = $clog2(QUO_W);

   // item kinds
   localparam logic KIND_LOAD  = 1'b0;
   localparam logic KIND_QUERY = 1'b1;

   // track codes
   localparam logic [TRACK_W-1:0] TRACK_TRANS = 2'd0;
   localparam logic [TRACK_W-1:0] TRACK_ROT   = 2'd1;
   localparam logic [TRACK_W-1:0] TRACK_SCALE = 2'd2;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_TRANS_COUNT = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ROT_COUNT   = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_SCALE_COUNT = 2'd2;

   typedef logic [NUM_COMP-1:0][KEY_W-1:0] pose_type;

   typedef struct packed {
      logic [KEY_W-1:0] stamp;
      pose_type         value;
   } key_type;

endpackage

FILE: hw/rtl/kli_req_if.sv
interface kli_req_if;
   logic                                valid;
   logic                                ready;
   logic                                kind;
   logic [kli_pkg::TRACK_W-1:0]         track;
   logic [kli_pkg::SLOT_W-1:0]          key_slot;
   logic signed [kli_pkg::KEY_W-1:0]    key_time;
   logic signed [kli_pkg::KEY_W-1:0]    key_x;
   logic signed [kli_pkg::KEY_W-1:0]    key_y;
   logic signed [kli_pkg::KEY_W-1:0]    key_z;
   logic signed [kli_pkg::KEY_W-1:0]    frame;

   modport source (
      output valid, kind, track, key_slot, key_time, key_x, key_y, key_z, frame,
      input  ready
   );
   modport sink (
      input  valid, kind, track, key_slot, key_time, key_x, key_y, key_z, frame,
      output ready
   );
endinterface

FILE: hw/rtl/kli_rsp_if.sv
interface kli_rsp_if;
   logic                             valid;
   logic                             ready;
   logic signed [kli_pkg::KEY_W-1:0] trans_x;
   logic signed [kli_pkg::KEY_W-1:0] trans_y;
   logic signed [kli_pkg::KEY_W-1:0] trans_z;
   logic signed [kli_pkg::KEY_W-1:0] rot_x;
   logic signed [kli_pkg::KEY_W-1:0] rot_y;
   logic signed [kli_pkg::KEY_W-1:0] rot_z;
   logic signed [kli_pkg::KEY_W-1:0] scale_x;
   logic signed [kli_pkg::KEY_W-1:0] scale_y;
   logic signed [kli_pkg::KEY_W-1:0] scale_z;

   modport source (
      output valid, trans_x, trans_y, trans_z, rot_x, rot_y, rot_z,
             scale_x, scale_y, scale_z,
      input  ready
   );
   modport sink (
      input  valid, trans_x, trans_y, trans_z, rot_x, rot_y, rot_z,
             scale_x, scale_y, scale_z,
      output ready
   );
endinterface

FILE: hw/rtl/keyframe_linear_interpolator.sv
// Keyframe linear interpolator: three tracks (translation, rotation, scaling)
// of up to MAX_KEYS keys each, held in one single-port key memory.
// req_ch: a load item (kind 0) writes one key if its track and slot are valid, and gives no result.
//         A query item (kind 1) gives one result on rsp_ch with nine components.
// csr_*:  key count per track, written only while the block is idle; the
//         block itself does not enforce this, so the user must keep to it.
// A query searches each track in turn, reading its keys one at a time; when
// the frame falls between two keys, each component takes one multiply, 16
// restoring-divide steps and one add, and the result is posted at the end.
// The multiplier/divider is shared and the key memory has one read port.
// req_ch.ready is low while a query is at work; loads leave it high.
// The result sits in an output register: the block takes further load items
// while it waits, and a second query finishes and then holds until rsp_ch
// takes the first result.
// Reset clears the key counts, the held pose of each track and the output
// valid. Key memory contents are undefined until loaded.
module keyframe_linear_interpolator #(
   parameter int MAX_KEYS = kli_pkg::MAX_KEYS_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   kli_req_if.sink                            req_ch,
   kli_rsp_if.source                          rsp_ch,
   input  logic                               csr_we,
   input  logic [kli_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [kli_pkg::COUNT_W-1:0]        csr_wdata
);

   localparam int DEPTH  = kli_pkg::NUM_TRACKS * MAX_KEYS;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int CNT_W  = $clog2(MAX_KEYS + 1);
   localparam int KW     = kli_pkg::KEY_W;
   localparam int QW     = kli_pkg::QUO_W;
   localparam int DCW    = kli_pkg::DIV_CNT_W;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_TRACK,
      ST_CHECK,
      ST_MUL,
      ST_DIV,
      ST_SUM,
      ST_NEXT,
      ST_OUT
   } state_type;

   state_type                          state_ff;
   logic [kli_pkg::COUNT_W-1:0]        count_ff [kli_pkg::NUM_TRACKS];
   kli_pkg::key_type                   key_mem_ff [DEPTH];
   kli_pkg::key_type                   rd_data_ff;
   kli_pkg::key_type                   prev_ff;
   kli_pkg::key_type                   cur_ff;
   kli_pkg::pose_type                  held_ff [kli_pkg::NUM_TRACKS];
   kli_pkg::pose_type                  out_ff [kli_pkg::NUM_TRACKS];
   logic                               rsp_valid_ff;
   logic [KW-1:0]                      frame_ff;
   logic [kli_pkg::TRACK_W-1:0]        track_ff;
   logic [ADDR_W-1:0]                  base_ff;
   logic [CNT_W-1:0]                   n_ff;
   logic [CNT_W-1:0]                   idx_ff;
   logic [1:0]                         comp_ff;
   logic [KW-1:0]                      rel_ff;
   logic [KW-1:0]                      span_ff;
   logic [QW-1:0]                      rem_ff;
   logic [QW-1:0]                      quo_ff;
   logic                               neg_ff;
   logic [DCW-1:0]                     div_cnt_ff;

   logic                               req_fire;
   logic                               load_ok;
   logic [ADDR_W-1:0]                  wr_addr;
   logic [CNT_W-1:0]                   n_sat;
   logic [CNT_W-1:0]                   idx_next;
   logic                               key_lt;
   logic                               key_eq;
   logic                               key_last;
   logic                               take_key;
   logic                               interp;
   logic                               advance;
   logic                               rd_en;
   logic [ADDR_W-1:0]                  rd_addr;
   logic [KW:0]                        rel_wide;
   logic [KW:0]                        span_wide;
   logic [KW-1:0]                      diff;
   logic [KW-1:0]                      diff_mag;
   logic [2*KW-1:0]                    prod;
   logic [QW:0]                        div_shift;
   logic [QW:0]                        div_sub;
   logic                               div_bit;
   logic [QW-1:0]                      quo_signed;
   logic                               out_free;

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign req_fire     = req_ch.valid && req_ch.ready;
   assign out_free     = !rsp_valid_ff || rsp_ch.ready;

   assign load_ok = (req_ch.track <= kli_pkg::TRACK_SCALE)
                 && (32'(req_ch.key_slot) < MAX_KEYS);
   assign wr_addr = ADDR_W'(32'(req_ch.track) * MAX_KEYS + 32'(req_ch.key_slot));

   always_comb begin
      if (32'(count_ff[track_ff]) > MAX_KEYS) begin
         n_sat = CNT_W'(MAX_KEYS);
      end else begin
         n_sat = CNT_W'(count_ff[track_ff]);
      end
   end

   // search compare on the key just read
   always_comb begin
      idx_next = idx_ff + CNT_W'(1);
      key_lt   = $signed(frame_ff) < $signed(rd_data_ff.stamp);
      key_eq   = frame_ff == rd_data_ff.stamp;
      key_last = idx_next == n_ff;
      take_key = (n_ff == CNT_W'(1)) || key_eq || (key_lt && (idx_ff == '0));
      interp   = !take_key && key_lt;
      advance  = !take_key && !key_lt && !key_last;
      rd_en    = (state_ff == ST_TRACK) || ((state_ff == ST_CHECK) && advance);
      if (state_ff == ST_CHECK) begin
         rd_addr = base_ff + ADDR_W'(idx_next);
      end else begin
         rd_addr = base_ff;
      end
   end

   assign rel_wide  = {frame_ff[KW-1], frame_ff} - {prev_ff.stamp[KW-1], prev_ff.stamp};
   assign span_wide = {rd_data_ff.stamp[KW-1], rd_data_ff.stamp}
                    - {prev_ff.stamp[KW-1], prev_ff.stamp};

   // shared multiply: |diff| * rel, sign handled around the divider
   always_comb begin
      diff     = cur_ff.value[comp_ff] - prev_ff.value[comp_ff];
      diff_mag = diff[KW-1] ? (~diff + KW'(1)) : diff;
      prod     = {{KW{1'b0}}, diff_mag} * {{KW{1'b0}}, rel_ff};
   end

   // one restoring-divide step per cycle
   always_comb begin
      div_shift = {rem_ff, quo_ff[QW-1]};
      div_sub   = div_shift - {1'b0, span_ff};
      div_bit   = div_shift >= {1'b0, span_ff};
      quo_signed = neg_ff ? (~quo_ff + QW'(1)) : quo_ff;
   end

   always_ff @(posedge clock) begin
      if (req_fire && (req_ch.kind == kli_pkg::KIND_LOAD) && load_ok) begin
         key_mem_ff[wr_addr] <= '{stamp: req_ch.key_time,
                                  value: {req_ch.key_z, req_ch.key_y, req_ch.key_x}};
      end
      if (rd_en) begin
         rd_data_ff <= key_mem_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < kli_pkg::NUM_TRACKS; i++) begin
            count_ff[i] <= '0;
         end
      end else if (csr_we) begin
         case (csr_index)
            kli_pkg::CSR_TRANS_COUNT: count_ff[0] <= csr_wdata;
            kli_pkg::CSR_ROT_COUNT:   count_ff[1] <= csr_wdata;
            kli_pkg::CSR_SCALE_COUNT: count_ff[2] <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < kli_pkg::NUM_TRACKS; i++) begin
            held_ff[i] <= '0;
         end
      end else begin
         // a new result may replace one taken in the same cycle
         if ((state_ff == ST_OUT) && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.valid && rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_fire && (req_ch.kind == kli_pkg::KIND_QUERY)) begin
                  frame_ff <= req_ch.frame;
                  track_ff <= kli_pkg::TRACK_TRANS;
                  base_ff  <= '0;
                  state_ff <= ST_TRACK;
               end
            end
            ST_TRACK: begin
               n_ff   <= n_sat;
               idx_ff <= '0;
               if (n_sat == '0) begin
                  state_ff <= ST_NEXT;
               end else begin
                  state_ff <= ST_CHECK;
               end
            end
            ST_CHECK: begin
               if (take_key) begin
                  held_ff[track_ff] <= rd_data_ff.value;
                  state_ff <= ST_NEXT;
               end else if (interp) begin
                  cur_ff   <= rd_data_ff;
                  rel_ff   <= rel_wide[KW-1:0];
                  span_ff  <= span_wide[KW-1:0];
                  comp_ff  <= '0;
                  state_ff <= ST_MUL;
               end else if (key_last) begin
                  // frame past the last key: track keeps its pose
                  state_ff <= ST_NEXT;
               end else begin
                  prev_ff <= rd_data_ff;
                  idx_ff  <= idx_next;
               end
            end
            ST_MUL: begin
               // product < span * 2^15, so the high half is already below span
               rem_ff     <= prod[2*KW-1:KW];
               quo_ff     <= prod[KW-1:0];
               neg_ff     <= diff[KW-1];
               div_cnt_ff <= '0;
               state_ff   <= ST_DIV;
            end
            ST_DIV: begin
               rem_ff     <= div_bit ? div_sub[QW-1:0] : div_shift[QW-1:0];
               quo_ff     <= {quo_ff[QW-2:0], div_bit};
               div_cnt_ff <= div_cnt_ff + DCW'(1);
               if (div_cnt_ff == '1) begin
                  state_ff <= ST_SUM;
               end
            end
            ST_SUM: begin
               held_ff[track_ff][comp_ff] <= prev_ff.value[comp_ff] + quo_signed;
               if (comp_ff == 2'(kli_pkg::NUM_COMP - 1)) begin
                  state_ff <= ST_NEXT;
               end else begin
                  comp_ff  <= comp_ff + 2'd1;
                  state_ff <= ST_MUL;
               end
            end
            ST_NEXT: begin
               if (track_ff == kli_pkg::TRACK_SCALE) begin
                  state_ff <= ST_OUT;
               end else begin
                  track_ff <= track_ff + 2'd1;
                  base_ff  <= base_ff + ADDR_W'(MAX_KEYS);
                  state_ff <= ST_TRACK;
               end
            end
            ST_OUT: begin
               if (out_free) begin
                  for (int i = 0; i < kli_pkg::NUM_TRACKS; i++) begin
                     out_ff[i] <= held_ff[i];
                  end
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_ch.valid   = rsp_valid_ff;
   assign rsp_ch.trans_x = out_ff[0][0];
   assign rsp_ch.trans_y = out_ff[0][1];
   assign rsp_ch.trans_z = out_ff[0][2];
   assign rsp_ch.rot_x   = out_ff[1][0];
   assign rsp_ch.rot_y   = out_ff[1][1];
   assign rsp_ch.rot_z   = out_ff[1][2];
   assign rsp_ch.scale_x = out_ff[2][0];
   assign rsp_ch.scale_y = out_ff[2][1];
   assign rsp_ch.scale_z = out_ff[2][2];

`ifndef SYNTHESIS
   // search never runs past the key count
   a_idx_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CHECK) |-> (idx_ff < n_ff))
      else $error("key index beyond track count");

   // a query holds off further items
   a_query_busy: assert property (@(posedge clock) disable iff (reset)
      (req_fire && (req_ch.kind == kli_pkg::KIND_QUERY)) |=> !req_ch.ready)
      else $error("ready after query accept");

   // rel < span bounds the quotient magnitude below 2^15
   a_quo_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SUM) |-> !quo_ff[QW-1])
      else $error("quotient out of range");

   a_rsp_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_OUT))
      else $error("result posted outside output state");
`endif

endmodule

FILE: test/keyframe_linear_interpolator_tb.sv
module keyframe_linear_interpolator_tb;

   localparam int MAX_KEYS     = kli_pkg::MAX_KEYS_DEFAULT;
   localparam int TRACK_W      = kli_pkg::TRACK_W;
   localparam int SLOT_W       = kli_pkg::SLOT_W;
   localparam int KEY_W        = kli_pkg::KEY_W;
   localparam int COUNT_W      = kli_pkg::COUNT_W;
   localparam int CSR_INDEX_W  = kli_pkg::CSR_INDEX_W;
   localparam int NUM_TRACKS   = kli_pkg::NUM_TRACKS;
   localparam int NUM_COMP     = kli_pkg::NUM_COMP;
   localparam int ITEM_TARGET  = 1300;
   localparam int DRAIN_CYCLES = 220;     // sized for the worst-case query
   localparam int HOLD_CYCLES  = 400;
   localparam int CYCLE_LIMIT  = 1500000;

   // no such track: loads to it are dropped
   localparam logic [TRACK_W-1:0] TRACK_NONE = 2'd3;

   typedef struct packed {
      logic               kind;
      logic [TRACK_W-1:0] track;
      logic [SLOT_W-1:0]  slot;
      logic [KEY_W-1:0]   stamp;
      kli_pkg::pose_type  val;
      logic [KEY_W-1:0]   frame;
   } kf_item_type;

   // nine components, trans_x at index 0
   typedef logic [NUM_TRACKS*NUM_COMP-1:0][KEY_W-1:0] full_pose_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = kli_pkg::CSR_TRANS_COUNT;
   logic [COUNT_W-1:0] csr_wdata = '0;

   kf_item_type drv_item = '0;
   logic req_valid_d = 1'b0;
   logic rsp_ready_d = 1'b0;
   logic req_taken = 1'b0;

   kli_req_if req_ch();
   kli_rsp_if rsp_ch();

   assign req_ch.valid    = req_valid_d;
   assign req_ch.kind     = drv_item.kind;
   assign req_ch.track    = drv_item.track;
   assign req_ch.key_slot = drv_item.slot;
   assign req_ch.key_time = drv_item.stamp;
   assign req_ch.key_x    = drv_item.val[0];
   assign req_ch.key_y    = drv_item.val[1];
   assign req_ch.key_z    = drv_item.val[2];
   assign req_ch.frame    = drv_item.frame;
   assign rsp_ch.ready    = rsp_ready_d;

   keyframe_linear_interpolator #(.MAX_KEYS(MAX_KEYS)) uut (
      .clock    (clock),
      .reset    (reset),
      .req_ch   (req_ch),
      .rsp_ch   (rsp_ch),
      .csr_we   (csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // ---------------- pose model ----------------
   logic [COUNT_W-1:0] count_m[NUM_TRACKS] = '{default: '0};
   logic [KEY_W-1:0]   key_stamp_m[NUM_TRACKS][MAX_KEYS];
   kli_pkg::pose_type  key_val_m[NUM_TRACKS][MAX_KEYS];
   kli_pkg::pose_type  held_m[NUM_TRACKS] = '{default: '0};

   function automatic void eval_track_pose(int tr, logic signed [KEY_W-1:0] frame);
      int n, i, c;
      bit found;
      longint t, tp, span, rel, q;
      logic [KEY_W-1:0] pv, dw;
      n = (count_m[tr] > MAX_KEYS) ? MAX_KEYS : int'(count_m[tr]);
      if (n == 0) return;
      if (n == 1) begin
         held_m[tr] = key_val_m[tr][0];
         return;
      end
      found = 1'b0;
      for (i = 0; i < n && !found; i++) begin
         t = longint'($signed(key_stamp_m[tr][i]));
         if (longint'(frame) < t) begin
            found = 1'b1;
            if (i == 0) begin
               held_m[tr] = key_val_m[tr][0];
            end else begin
               tp = longint'($signed(key_stamp_m[tr][i-1]));
               span = t - tp;
               rel = longint'(frame) - tp;
               for (c = 0; c < NUM_COMP; c++) begin
                  pv = key_val_m[tr][i-1][c];
                  dw = key_val_m[tr][i][c] - pv;
                  q = (longint'($signed(dw)) * rel) / span;
                  held_m[tr][c] = pv + q[KEY_W-1:0];
               end
            end
         end else if (longint'(frame) == t) begin
            found = 1'b1;
            held_m[tr] = key_val_m[tr][i];
         end
      end
   endfunction

   // returns 1 when the item yields a pose
   function automatic bit interpolate_item(input kf_item_type it, output full_pose_type pose);
      int tr;
      pose = '0;
      if (it.kind == kli_pkg::KIND_LOAD) begin
         if (it.track <= kli_pkg::TRACK_SCALE && int'(it.slot) < MAX_KEYS) begin
            key_stamp_m[it.track][it.slot] = it.stamp;
            key_val_m[it.track][it.slot] = it.val;
         end
         return 1'b0;
      end
      for (tr = 0; tr < NUM_TRACKS; tr++)
         eval_track_pose(tr, it.frame);
      pose = {held_m[2], held_m[1], held_m[0]};
      return 1'b1;
   endfunction

   // ---------------- bookkeeping ----------------
   kf_item_type   req_backlog[$];
   full_pose_type pose_due[$];
   int mismatches = 0;
   int cycles = 0;
   int accepted = 0;
   int queries_taken = 0;
   int poses_checked = 0;
   int settings = 0;
   int hold_req = 0;
   int hold_done = 0;
   bit offering = 1'b0;

   string comp_name[NUM_TRACKS*NUM_COMP] = '{"trans_x", "trans_y", "trans_z",
      "rot_x", "rot_y", "rot_z", "scale_x", "scale_y", "scale_z"};

   task automatic flag_mismatch(string what);
      mismatches++;
      if (mismatches <= 100)
         $display("MISMATCH @%0d: %s", cycles, what);
   endtask

   // ---------------- sender ----------------
   int burst_left = 0;
   int gap_left = 0;

   always @(negedge clock) begin
      int r;
      if (req_taken) offering = 1'b0;
      if (!offering && !reset) begin
         if (gap_left > 0) begin
            gap_left--;
         end else if (req_backlog.size() > 0) begin
            drv_item <= req_backlog.pop_front();
            offering = 1'b1;
            burst_left--;
            if (burst_left <= 0) begin
               burst_left = $urandom_range(1, 24);
               r = $urandom_range(0, 99);
               if (r < 35) gap_left = 0;
               else if (r < 85) gap_left = $urandom_range(1, 6);
               else gap_left = $urandom_range(10, 40);
            end
         end
      end
      req_valid_d <= offering;
   end

   // ---------------- receiver ----------------
   int hold_left = 0;
   int mode_left = 0;
   int sink_mode = 0;

   always @(negedge clock) begin
      bit rdy;
      if (hold_left > 0) begin
         hold_left--;
      end else if (hold_done != hold_req) begin
         hold_left = HOLD_CYCLES;
         hold_done++;
      end
      if (mode_left == 0) begin
         sink_mode = $urandom_range(0, 2);
         mode_left = $urandom_range(20, 200);
      end else begin
         mode_left--;
      end
      case (sink_mode)
         0: rdy = 1'b1;
         1: rdy = 1'($urandom_range(0, 1));
         default: rdy = ($urandom_range(0, 5) == 0);
      endcase
      rsp_ready_d <= (hold_left == 0) && rdy;
   end

   // ---------------- monitor and checker ----------------
   always @(posedge clock) begin
      full_pose_type got, want;
      int c;
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d poses still due", cycles, pose_due.size());
         $display("keyframe_linear_interpolator_tb failed");
         $finish;
      end
      req_taken <= !reset && req_ch.valid && req_ch.ready;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got = {rsp_ch.scale_z, rsp_ch.scale_y, rsp_ch.scale_x,
                rsp_ch.rot_z, rsp_ch.rot_y, rsp_ch.rot_x,
                rsp_ch.trans_z, rsp_ch.trans_y, rsp_ch.trans_x};
         if (pose_due.size() == 0) begin
            flag_mismatch("result with no query outstanding");
         end else begin
            want = pose_due.pop_front();
            for (c = 0; c < NUM_TRACKS*NUM_COMP; c++)
               if (got[c] !== want[c])
                  flag_mismatch($sformatf("pose %0d %s: got %h expected %h",
                     poses_checked, comp_name[c], got[c], want[c]));
         end
         poses_checked++;
      end
      if (!reset && req_ch.valid && req_ch.ready) begin
         accepted++;
         if (interpolate_item(drv_item, want)) begin
            pose_due.push_back(want);
            queries_taken++;
         end
      end
   end

   // ---------------- stimulus ----------------
   int gen_stamp[NUM_TRACKS][MAX_KEYS];
   bit gen_written[NUM_TRACKS][MAX_KEYS] = '{default: '0};
   int made = 0;

   function automatic int clamp16(int v);
      if (v > 32767) return 32767;
      if (v < -32768) return -32768;
      return v;
   endfunction

   function automatic int written_prefix(int tr);
      int k;
      for (k = 0; k < MAX_KEYS; k++)
         if (!gen_written[tr][k]) return k;
      return MAX_KEYS;
   endfunction

   function automatic logic [KEY_W-1:0] rand_comp();
      int r;
      r = $urandom_range(0, 99);
      if (r < 4) return 16'h7fff;
      if (r < 8) return 16'h8000;
      if (r < 11) return 16'h0000;
      if (r < 15) return 16'hffff;
      return KEY_W'($urandom);
   endfunction

   task automatic add_load(logic [TRACK_W-1:0] tr, int slot, int t,
                           logic [KEY_W-1:0] x, logic [KEY_W-1:0] y, logic [KEY_W-1:0] z);
      kf_item_type it;
      it = '0;
      it.kind = kli_pkg::KIND_LOAD;
      it.track = tr;
      it.slot = SLOT_W'(slot);
      it.stamp = KEY_W'(t);
      it.val = {z, y, x};
      it.frame = KEY_W'($urandom);
      req_backlog.push_back(it);
      if (tr <= kli_pkg::TRACK_SCALE) begin
         made++;
         gen_stamp[tr][slot] = clamp16(t);
         gen_written[tr][slot] = 1'b1;
      end
   endtask

   task automatic add_query(int f);
      kf_item_type it;
      it = '0;
      it.kind = kli_pkg::KIND_QUERY;
      it.track = TRACK_W'($urandom);
      it.slot = SLOT_W'($urandom);
      it.stamp = KEY_W'($urandom);
      it.val = {rand_comp(), rand_comp(), rand_comp()};
      it.frame = KEY_W'(f);
      req_backlog.push_back(it);
      made++;
   endtask

   // wait until everything sent has been answered, then let the block finish
   task automatic settle();
      do @(posedge clock);
      while (req_backlog.size() != 0 || offering || pose_due.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(logic [CSR_INDEX_W-1:0] idx, logic [COUNT_W-1:0] val);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      count_m[idx] = val;
   endtask

   task automatic set_counts(int a, int b, int c);
      settle();
      csr_write(kli_pkg::CSR_TRANS_COUNT, COUNT_W'(a));
      csr_write(kli_pkg::CSR_ROT_COUNT, COUNT_W'(b));
      csr_write(kli_pkg::CSR_SCALE_COUNT, COUNT_W'(c));
      @(negedge clock);
      csr_we <= 1'b0;
      settings++;
   endtask

   task automatic load_track(int tr, int n, bit sorted);
      int t, maxstep, k, room, r;
      r = $urandom_range(0, 2);
      maxstep = (r == 0) ? 4 : (r == 1) ? 300 : 65535 / n;
      room = 65535 - n * maxstep;
      t = (room > 0) ? int'($urandom_range(0, room)) - 32768 : -32768;
      for (k = 0; k < n; k++) begin
         if (!sorted) t = int'($urandom_range(0, 65535)) - 32768;
         add_load(TRACK_W'(tr), k, t, rand_comp(), rand_comp(), rand_comp());
         if (sorted) begin
            // an occasional repeated time
            if ($urandom_range(0, 19) != 0) t = clamp16(t + int'($urandom_range(1, maxstep)));
         end
      end
   endtask

   function automatic int pick_count(int tr, int loaded);
      int p, r;
      p = written_prefix(tr);
      r = $urandom_range(0, 99);
      if (r < 8 || p == 0) return 0;
      if (r < 16) return 1;
      if (p == MAX_KEYS && r < 26) return $urandom_range(MAX_KEYS + 1, 31);
      if (p == MAX_KEYS && r < 34) return MAX_KEYS;
      if (loaded > 0 && r < 80) return loaded;
      if (p < 2) return p;
      return $urandom_range(2, p);
   endfunction

   function automatic int pick_frame();
      int tr, n, k, t0, t1, r;
      r = $urandom_range(0, 99);
      tr = $urandom_range(0, NUM_TRACKS - 1);
      n = (count_m[tr] > MAX_KEYS) ? MAX_KEYS : int'(count_m[tr]);
      if (r < 12 || n == 0) return int'($urandom_range(0, 65535)) - 32768;
      k = $urandom_range(0, n - 1);
      t0 = gen_stamp[tr][k];
      if (r < 35) return t0;
      if (r < 45) return clamp16(t0 - int'($urandom_range(1, 50)));
      if (k + 1 < n) begin
         t1 = gen_stamp[tr][k+1];
         if (t1 > t0) return t0 + int'($urandom_range(0, t1 - t0));
      end
      return clamp16(t0 + int'($urandom_range(1, 50)));
   endfunction

   initial begin
      int phase, tr, n, nq, r, slot;
      int loaded[NUM_TRACKS];
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // empty tracks hold zero; the missing track is ignored
      add_query(0);
      add_load(TRACK_NONE, 0, 5, 16'h1111, 16'h2222, 16'h3333);
      add_load(kli_pkg::TRACK_TRANS, 0, -32768, 16'h7fff, 16'h8000, 16'h0001);
      add_load(kli_pkg::TRACK_ROT, 0, 0, 16'h1234, 16'hedcb, 16'h0000);
      add_load(kli_pkg::TRACK_SCALE, 0, 32767, 16'hffff, 16'h0000, 16'h7fff);
      add_query(100);
      // one key per track
      set_counts(1, 1, 1);
      add_query(-32768);
      add_query(32767);
      // second keys: wrapping differences, full span, a descending pair
      add_load(kli_pkg::TRACK_TRANS, 1, 32767, 16'h8000, 16'h7fff, 16'hffff);
      add_load(kli_pkg::TRACK_ROT, 1, 10, 16'h1000, 16'h8000, 16'h0100);
      add_load(kli_pkg::TRACK_SCALE, 1, -32768, 16'h0000, 16'h8000, 16'h7fff);
      set_counts(2, 2, 2);
      add_query(-32768);
      add_query(0);
      add_query(5);
      add_query(32767);
      add_query(32766);
      add_query(20);
      add_query(-1);

      phase = 0;
      while (made < ITEM_TARGET) begin
         phase++;
         for (tr = 0; tr < NUM_TRACKS; tr++) begin
            loaded[tr] = 0;
            if ($urandom_range(0, 3) != 0 || written_prefix(tr) == 0) begin
               n = ($urandom_range(0, 4) == 0) ? MAX_KEYS : $urandom_range(1, MAX_KEYS);
               load_track(tr, n, $urandom_range(0, 9) != 0);
               loaded[tr] = n;
            end
         end
         set_counts(pick_count(0, loaded[0]), pick_count(1, loaded[1]),
                    pick_count(2, loaded[2]));
         // let the result side back up while items keep coming
         if (phase % 6 == 0) hold_req++;
         nq = $urandom_range(8, 40);
         repeat (nq) begin
            r = $urandom_range(0, 99);
            if (r < 8) begin
               tr = $urandom_range(0, NUM_TRACKS - 1);
               n = (count_m[tr] > MAX_KEYS) ? MAX_KEYS : int'(count_m[tr]);
               slot = (n > 0) ? $urandom_range(0, n - 1) : $urandom_range(0, MAX_KEYS - 1);
               add_load(TRACK_W'(tr), slot,
                        (gen_written[tr][slot] && $urandom_range(0, 9) < 7) ?
                           gen_stamp[tr][slot] : int'($urandom_range(0, 65535)) - 32768,
                        rand_comp(), rand_comp(), rand_comp());
            end else if (r < 11) begin
               add_load(TRACK_NONE, $urandom_range(0, MAX_KEYS - 1),
                        int'($urandom_range(0, 65535)) - 32768,
                        rand_comp(), rand_comp(), rand_comp());
            end else begin
               add_query(pick_frame());
            end
         end
      end

      settle();
      $display("covered %0d items (%0d queries) over %0d count settings; %0d poses compared",
               accepted, queries_taken, settings, poses_checked);
      $display("%0d long result-side stalls, %0d mismatches", hold_done, mismatches);
      if (mismatches == 0) begin
         $display("keyframe_linear_interpolator_tb passed");
      end else begin
         $display("keyframe_linear_interpolator_tb failed");
      end
      $finish;
   end

endmodule

FILE: sim.f
hw/rtl/kli_pkg.sv
hw/rtl/kli_req_if.sv
hw/rtl/kli_rsp_if.sv
hw/rtl/keyframe_linear_interpolator.sv
test/keyframe_linear_interpolator_tb.sv
